[rtl/core/modular_exponentiation_defines.svh]
// Assertion macros used by the modular exponentiation controller.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH
`ifndef SYNTHESIS
// checked out of reset only
`define MEXP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MEXP_ASSERT(lbl, prop, msg)
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/mexp_pkg.sv]
package mexp_pkg;

    localparam int VALUE_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_DATA_W-1:0] MODULUS_RESET  = 16'd3233;
    localparam logic [CFG_DATA_W-1:0] EXPONENT_RESET = 16'd17;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULUS  = 1'b0,
        REG_EXPONENT = 1'b1
    } cfg_reg_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // take base_value and exponent
        logic reduce;    // step pass that reduces the base
        logic step;      // one serial multiply step
        logic rcommit;   // store reduced base, acc = 1
        logic load;      // start a multiply/square pass
        logic commit;    // store square, and product on a set exponent bit
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mod_lt2;
        logic exp_zero;
        logic exp_last;
    } status_t;

endpackage

[rtl/core/modular_exponentiation.sv]
// Modular exponentiation: result_value = base_value ^ exponent mod modulus,
// right-to-left square-and-multiply with bit-serial modular multipliers.
// Configuration: cfg_wr_en/cfg_addr/cfg_wr_data write modulus (index 0) or
// exponent (index 1) at a clock edge; write only while busy is low.
// Input: a transfer happens at an edge with start high and busy low.
// Output: done is high for one cycle with result_value; the receiver
// cannot stall and must take it in that cycle.
// A zero exponent gives 1; a modulus below 2 gives 0 in the cycle after
// the transfer. The next start is taken in the done cycle. The serial
// multipliers take one multiplier bit per cycle; multiply and square run
// side by side on the same bit.
// Reset: modulus 3233, exponent 17, controller idle, no result pending.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = 16,
    parameter int EXP_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_W-1:0]    base_value,
    output logic                  done,
    output logic [VALUE_W-1:0]    result_value
);

    localparam int OPW = (MOD_BITS > VALUE_W) ? MOD_BITS : VALUE_W;

    cmd_t    cmd;
    status_t status;

    mexp_ctrl #(
        .OPW(OPW)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mexp_dp #(
        .MOD_BITS(MOD_BITS),
        .EXP_BITS(EXP_BITS),
        .OPW     (OPW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .base_value   (base_value),
        .cmd          (cmd),
        .status       (status),
        .result_value (result_value)
    );

endmodule

[rtl/core/mexp_dp.sv]
module mexp_dp
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = 16,
    parameter int EXP_BITS = 16,
    parameter int OPW      = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [VALUE_W-1:0]    base_value,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [VALUE_W-1:0]    result_value
);

    localparam int SCAN_W = (EXP_BITS < CFG_DATA_W) ? EXP_BITS : CFG_DATA_W;

    logic [MOD_BITS-1:0] modulus_reg;
    logic [SCAN_W-1:0]   exponent_reg;
    logic [SCAN_W-1:0]   exp_sh_reg;
    logic [OPW-1:0]      y_reg;
    logic [MOD_BITS-1:0] ra_reg;
    logic [MOD_BITS-1:0] rb_reg;
    logic [MOD_BITS-1:0] base_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] ra_next;
    logic [MOD_BITS-1:0] rb_next;
    logic [MOD_BITS-1:0] xb;

    // interleaved modular multiply step: r = (2r + b*x) mod m, r and x below m
    function automatic logic [MOD_BITS-1:0] mm_step(
        input logic [MOD_BITS-1:0] r,
        input logic [MOD_BITS-1:0] x,
        input logic [MOD_BITS-1:0] m,
        input logic                b
    );
        logic [MOD_BITS:0] t;
        logic [MOD_BITS:0] mx;
        begin
            mx = {1'b0, m};
            t  = {r, 1'b0};
            if (t >= mx)
                t = t - mx;
            if (b)
                t = t + {1'b0, x};
            if (t >= mx)
                t = t - mx;
            mm_step = t[MOD_BITS-1:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MOD_BITS'(MODULUS_RESET);
            exponent_reg <= SCAN_W'(EXPONENT_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MODULUS:  modulus_reg  <= MOD_BITS'(cfg_wr_data);
                REG_EXPONENT: exponent_reg <= SCAN_W'(cfg_wr_data);
            endcase
        end
    end

    // during base reduction unit B computes 1 * base mod m
    assign xb      = cmd.reduce ? MOD_BITS'(1) : base_reg;
    assign ra_next = mm_step(ra_reg, acc_reg, modulus_reg, y_reg[OPW-1]);
    assign rb_next = mm_step(rb_reg, xb, modulus_reg, y_reg[OPW-1]);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            y_reg      <= OPW'(base_value);
            ra_reg     <= '0;
            rb_reg     <= '0;
            exp_sh_reg <= exponent_reg;
        end
        else if (cmd.load)
        begin
            y_reg  <= OPW'(base_reg);
            ra_reg <= '0;
            rb_reg <= '0;
        end
        else if (cmd.step)
        begin
            y_reg  <= y_reg << 1;
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
        else if (cmd.rcommit)
        begin
            base_reg <= rb_reg;
            acc_reg  <= MOD_BITS'(1);
        end
        else if (cmd.commit)
        begin
            if (exp_sh_reg[0])
                acc_reg <= ra_reg;
            base_reg   <= rb_reg;
            exp_sh_reg <= exp_sh_reg >> 1;
        end
    end

    assign status.mod_lt2  = (modulus_reg < MOD_BITS'(2));
    assign status.exp_zero = (exp_sh_reg == '0);
    assign status.exp_last = ((exp_sh_reg >> 1) == '0);

    assign result_value = status.mod_lt2 ? '0 : VALUE_W'(acc_reg);

endmodule

[rtl/core/mexp_ctrl.sv]
`include "modular_exponentiation_defines.svh"

module mexp_ctrl
    import mexp_pkg::*;
#(
    parameter int OPW = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    localparam int CNT_W = $clog2(OPW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPW - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_RCOMMIT,
        S_LOAD,
        S_STEP,
        S_COMMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.capture = (state_reg == S_IDLE) && start;
        cmd.reduce  = (state_reg == S_REDUCE);
        cmd.step    = (state_reg == S_REDUCE) || (state_reg == S_STEP);
        cmd.rcommit = (state_reg == S_RCOMMIT);
        cmd.load    = (state_reg == S_LOAD);
        cmd.commit  = (state_reg == S_COMMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        // modulus below 2: answer at once
                        if (status.mod_lt2)
                            done_reg <= 1'b1;
                        else
                        begin
                            state_reg <= S_REDUCE;
                            busy_reg  <= 1'b1;
                        end
                    end
                end
                S_REDUCE:
                begin
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_RCOMMIT;
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_RCOMMIT:
                begin
                    if (status.exp_zero)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                    state_reg <= S_STEP;
                S_STEP:
                begin
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_COMMIT;
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_COMMIT:
                begin
                    // stop once no set exponent bit remains
                    if (status.exp_last)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else
                        state_reg <= S_LOAD;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `MEXP_ASSERT(a_done_not_busy, !(done_reg && busy_reg), "done while busy")
    `MEXP_ASSERT(a_busy_tracks_state, busy_reg == (state_reg != S_IDLE), "busy out of step")
    `MEXP_ASSERT(a_accept_progress, (start && !busy_reg) |=> (busy_reg || done_reg), "transfer lost")
    `MEXP_ASSERT(a_cnt_in_pass, (cnt_reg != '0) |-> (state_reg == S_REDUCE || state_reg == S_STEP), "stray step count")

endmodule

[dv/tb.sv]
module tb;
    import mexp_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] residue;
    } residue_check_t;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned TAIL_CYCLES = 320;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr    = REG_MODULUS;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  start       = 1'b0;
    logic [VALUE_W-1:0]    base_value  = '0;
    logic                  busy;
    logic                  done;
    logic [VALUE_W-1:0]    result_value;

    // local copy of the two registers
    logic [CFG_DATA_W-1:0] modulus_reg  = MODULUS_RESET;
    logic [CFG_DATA_W-1:0] exponent_reg = EXPONENT_RESET;

    logic [VALUE_W-1:0] pending_bases[$];
    residue_check_t     expected_residues[$];
    int unsigned        idle_left  = 0;
    bit                 no_gaps    = 1'b0;
    int unsigned        errors     = 0;
    int unsigned        stall_cnt  = 0;

    modular_exponentiation uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .start        (start),
        .busy         (busy),
        .base_value   (base_value),
        .done         (done),
        .result_value (result_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // right-to-left square-and-multiply
    function automatic logic [VALUE_W-1:0] modexp_residue(logic [VALUE_W-1:0] b,
                                                          logic [CFG_DATA_W-1:0] e,
                                                          logic [CFG_DATA_W-1:0] m);
        longint unsigned acc;
        longint unsigned pw;
        acc = 1;
        if (m < 2)
            return '0;
        pw = b % m;
        for (int i = 0; i < 16; i++)
        begin
            if (e[i])
                acc = (acc * pw) % m;
            pw = (pw * pw) % m;
        end
        return acc[VALUE_W-1:0];
    endfunction

    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 4);
        else if (r < 97)
            return $urandom_range(5, 40);
        else
            return $urandom_range(100, 400);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_base(logic [CFG_DATA_W-1:0] m);
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = VALUE_W'($urandom_range(0, 65535));
            5:       v = VALUE_W'($urandom_range(0, 1));
            6:       v = m - 16'd1;
            7:       v = m;
            8:       v = m + VALUE_W'($urandom_range(1, 8));
            default: v = 16'hFFFF - VALUE_W'($urandom_range(0, 3));
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && busy)
        begin
            // hold the item until the block takes it
        end
        else
        begin
            if (start)
                expected_residues.push_back('{base_value,
                    modexp_residue(base_value, exponent_reg, modulus_reg)});
            if (idle_left != 0)
            begin
                idle_left <= idle_left - 1;
                start     <= 1'b0;
            end
            else if (pending_bases.size() != 0)
            begin
                base_value <= pending_bases.pop_front();
                start      <= 1'b1;
                idle_left  <= no_gaps ? 0 : next_gap();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        residue_check_t exp_item;
        if (rst_n && done)
        begin
            if (expected_residues.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with nothing expected", result_value));
            end
            else
            begin
                exp_item = expected_residues.pop_front();
                if (result_value !== exp_item.residue)
                    report_mismatch($sformatf("base %0d: result_value %0d, expected %0d",
                                              exp_item.base, result_value,
                                              exp_item.residue));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cnt <= 0;
        end
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("modular_exponentiation test failed");
            $finish;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // sampled away from the rising edge so all updates of that edge have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bases.size() != 0 || expected_residues.size() != 0 || start || busy);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MODULUS)
            modulus_reg = data;
        else
            exponent_reg = data;
    endtask

    task automatic set_key(logic [CFG_DATA_W-1:0] m, logic [CFG_DATA_W-1:0] e);
        wait_idle();
        write_reg(REG_MODULUS, m);
        write_reg(REG_EXPONENT, e);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] m;
        logic [CFG_DATA_W-1:0] e;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key (n = 61*53, e = 17): zero, one, top value, around the modulus, 65
        no_gaps = 1'b1;
        pending_bases = '{16'd0, 16'd1, 16'hFFFF, 16'd3232, 16'd3233, 16'd3234, 16'd65};
        wait_idle();

        // private exponent undoes the reset key on 65^17 mod 3233 = 2790
        no_gaps = 1'b0;
        set_key(16'd3233, 16'd2753);
        pending_bases = '{16'd2790, 16'd855, 16'hFFFF};

        // zero exponent gives 1, also for a zero base
        set_key(16'd3233, 16'd0);
        pending_bases = '{16'd0, 16'd5};

        // modulus below two gives 0
        set_key(16'd0, 16'd17);
        pending_bases = '{16'd7, 16'hFFFF};
        set_key(16'd1, 16'hFFFF);
        pending_bases = '{16'd0, 16'd9};

        // widest values, then the smallest modulus that is worked, 2
        set_key(16'hFFFF, 16'hFFFF);
        pending_bases = '{16'hFFFF, 16'hFFFE, 16'd2, 16'd0};
        set_key(16'd2, 16'd1);
        pending_bases = '{16'd0, 16'd1, 16'd3};

        for (int p = 0; p < 19; p++)
        begin
            case ($urandom_range(0, 9))
                0:       m = CFG_DATA_W'($urandom_range(0, 1));
                1:       m = 16'd2;
                2:       m = 16'hFFFF;
                3:       m = 16'd3233;
                4:       m = $urandom_range(0, 1) ? 16'd61 : 16'd53;
                default: m = CFG_DATA_W'($urandom_range(2, 65535));
            endcase
            case ($urandom_range(0, 9))
                0:       e = 16'd0;
                1:       e = 16'd1;
                2:       e = 16'hFFFF;
                3:       e = 16'd17;
                4:       e = 16'd2753;
                5, 6:    e = CFG_DATA_W'($urandom_range(2, 255));
                default: e = CFG_DATA_W'($urandom_range(0, 65535));
            endcase
            set_key(m, e);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (100)
                pending_bases.push_back(pick_base(m));
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_residues.size() != 0)
            report_mismatch($sformatf("%0d results never came", expected_residues.size()));
        if (errors == 0)
            $display("modular_exponentiation test passed");
        else
            $display("modular_exponentiation test failed");
        $finish;
    end

endmodule

[modular_exponentiation.f]
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/mexp_dp.sv
rtl/core/mexp_ctrl.sv
rtl/core/modular_exponentiation.sv
dv/tb.sv
